// ----- sv/mvm_pkg.sv -----
// shared types and constants of the matrix-vector multiplier
package mvm_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 4;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 5;
    localparam int CFG_IW  = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_MATRIX = 2'd0,
        CMD_WR_VECTOR = 2'd1,
        CMD_COMPUTE   = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IW-1:0] {
        REG_NUM_ROWS = 2'd0,
        REG_NUM_COLS = 2'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic issue;
        logic next_row;
        logic push;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_compute;
        logic col_last;
        logic row_last;
        logic row_ready;
        logic out_free;
    } dp_status_t;

endpackage

// ----- sv/mvm_ram.sv -----
// generic single-write, single-read ram with registered read data
module mvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/mvm_ctrl.sv -----
// controller state machine of the matrix-vector multiplier
module mvm_ctrl
    import mvm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.is_compute)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.col_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (status.row_ready && status.out_free)
                begin
                    state_next = status.row_last ? ST_IDLE : ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                cmd.start  = in_valid && status.is_compute;
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
            end
            ST_WAIT:
            begin
                cmd.push     = status.row_ready && status.out_free;
                cmd.next_row = status.row_ready && status.out_free && !status.row_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/mvm_datapath.sv -----
// datapath: stores, counters, multiply-accumulate pipeline and output register
module mvm_datapath
    import mvm_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_cmd_t            cmd,
    output dp_status_t          status,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]    s_tuser,
    input  logic                cfg_valid,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CNT_W-1:0]    cfg_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    localparam int ROW_LIM = (MAX_ROWS < 16) ? MAX_ROWS : 16;
    localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int MAT_AW = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CW = (COL_AW > CNT_W) ? COL_AW : CNT_W;

    logic [CNT_W-1:0]  num_rows_reg;
    logic [CNT_W-1:0]  num_cols_reg;
    logic [CNT_W-1:0]  nr;
    logic [CNT_W-1:0]  nc;

    logic [IDX_W-1:0]  in_row;
    logic [IDX_W-1:0]  in_col;
    logic [VAL_W-1:0]  in_value;
    logic              in_range_mat;
    logic              in_range_vec;

    logic [IDX_W-1:0]  i_reg;
    logic [COL_AW-1:0] j_reg;

    logic              mat_we;
    logic              vec_we;
    logic [MAT_AW-1:0] mat_waddr;
    logic [MAT_AW-1:0] mat_raddr;
    logic [COL_AW-1:0] vec_waddr;
    logic [VAL_W-1:0]  mat_rdata;
    logic [VAL_W-1:0]  vec_rdata;

    logic              rd_v_reg;
    logic              rd_first_reg;
    logic              rd_last_reg;
    logic              prod_v_reg;
    logic              prod_first_reg;
    logic              prod_last_reg;
    logic [VAL_W-1:0]  prod_reg;
    logic [VAL_W-1:0]  acc_reg;
    logic [VAL_W-1:0]  acc_next;
    logic              row_ready_reg;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_row_reg;
    logic [VAL_W-1:0]  out_product_reg;
    logic              out_last_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= CNT_W'(16);
            num_cols_reg <= CNT_W'(16);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_NUM_ROWS)
            begin
                num_rows_reg <= cfg_data;
            end
            else if (cfg_index == REG_NUM_COLS)
            begin
                num_cols_reg <= cfg_data;
            end
        end
    end

    // counts in use
    always_comb
    begin
        if (num_rows_reg == '0)
        begin
            nr = CNT_W'(1);
        end
        else if (num_rows_reg > CNT_W'(ROW_LIM))
        begin
            nr = CNT_W'(ROW_LIM);
        end
        else
        begin
            nr = num_rows_reg;
        end

        if (num_cols_reg == '0)
        begin
            nc = CNT_W'(1);
        end
        else if ({4'b0, num_cols_reg} > 9'(MAX_COLS))
        begin
            nc = CNT_W'(MAX_COLS);
        end
        else
        begin
            nc = num_cols_reg;
        end
    end

    // element writes
    assign in_row       = s_tdata[IDX_W-1:0];
    assign in_col       = s_tdata[2*IDX_W-1:IDX_W];
    assign in_value     = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
    assign in_range_vec = {1'b0, in_col} < nc;
    assign in_range_mat = ({1'b0, in_row} < nr) && in_range_vec;

    assign mat_we    = cmd.accept && (s_tuser == CMD_WR_MATRIX) && in_range_mat;
    assign vec_we    = cmd.accept && (s_tuser == CMD_WR_VECTOR) && in_range_vec;
    assign mat_waddr = MAT_AW'(MAT_AW'(in_row) * MAT_AW'(MAX_COLS) + MAT_AW'(in_col));
    assign vec_waddr = COL_AW'(in_col);
    assign mat_raddr = MAT_AW'(MAT_AW'(i_reg) * MAT_AW'(MAX_COLS) + MAT_AW'(j_reg));

    mvm_ram #(
        .WIDTH(VAL_W),
        .DEPTH(MAT_DEPTH)
    ) u_matrix_ram (
        .clk  (clk),
        .we   (mat_we),
        .waddr(mat_waddr),
        .wdata(in_value),
        .raddr(mat_raddr),
        .rdata(mat_rdata)
    );

    mvm_ram #(
        .WIDTH(VAL_W),
        .DEPTH(MAX_COLS)
    ) u_vector_ram (
        .clk  (clk),
        .we   (vec_we),
        .waddr(vec_waddr),
        .wdata(in_value),
        .raddr(j_reg),
        .rdata(vec_rdata)
    );

    // row and column counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    j_reg <= status.col_last ? '0 : j_reg + COL_AW'(1);
                end
                if (cmd.next_row)
                begin
                    i_reg <= i_reg + IDX_W'(1);
                end
            end
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg       <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            prod_v_reg     <= 1'b0;
            prod_first_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            row_ready_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_v_reg       <= cmd.issue;
            rd_first_reg   <= cmd.issue && (j_reg == '0);
            rd_last_reg    <= cmd.issue && status.col_last;
            prod_v_reg     <= rd_v_reg;
            prod_first_reg <= rd_first_reg;
            prod_last_reg  <= rd_last_reg;
            if (cmd.push)
            begin
                row_ready_reg <= 1'b0;
            end
            else if (prod_v_reg && prod_last_reg)
            begin
                row_ready_reg <= 1'b1;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign acc_next = prod_first_reg ? prod_reg : acc_reg + prod_reg;

    // multiply, accumulate and result payload
    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            prod_reg <= VAL_W'(mat_rdata * vec_rdata);
        end
        if (prod_v_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.push)
        begin
            out_row_reg     <= i_reg;
            out_product_reg <= acc_reg;
            out_last_reg    <= status.row_last;
        end
    end

    assign status.is_compute = (s_tuser == CMD_COMPUTE);
    assign status.col_last   = CW'(j_reg) == CW'(nc - CNT_W'(1));
    assign status.row_last   = {1'b0, i_reg} == (nr - CNT_W'(1));
    assign status.row_ready  = row_ready_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W-IDX_W-VAL_W){1'b0}}, out_product_reg, out_row_reg};

    a_push_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid_reg || m_tready))
        else $error("result pushed into an occupied output register");

    a_issue_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> ({1'b0, i_reg} < nr))
        else $error("row counter beyond rows in use");

    a_no_issue_while_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !row_ready_reg)
        else $error("new row started before previous sum was pushed");

    a_start_empty_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> (!rd_v_reg && !prod_v_reg && !row_ready_reg))
        else $error("compute started with pipeline busy");

endmodule

// ----- sv/matrix_vector_multiply_top.sv -----
// Integer matrix-vector multiplier. Element writes (cmd 0 matrix, cmd 1 vector, selected on
// s_tuser) are taken while idle; writes outside the rows and columns in use are dropped. A
// compute transaction (cmd 2) walks the matrix one multiply-accumulate per cycle through the
// single 32x32 multiplier, reading matrix and vector ram in step, and between rows waits for
// the row's sum and a free output register; each row's 32-bit wrapped sum leaves through a
// registered output with m_tlast on the final row. Input is accepted again as soon as the
// last row sits in the output register. Ram contents are undefined until written.
module matrix_vector_multiply_top
    import mvm_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // row_index, col_index, value
    input  logic [CMD_W-1:0]    s_tuser,   // cmd
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_row, product, zero pad
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CNT_W-1:0]    cfg_data
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    mvm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    mvm_datapath #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the matrix-vector multiplier
module tb_top;
    import mvm_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
    } mvm_cmd_t;

    typedef struct {
        logic [3:0]  row;
        logic [31:0] product;
        logic        last;
    } row_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]    s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_IW-1:0]   cfg_index = '0;
    logic [CNT_W-1:0]    cfg_data = '0;

    mvm_cmd_t    cmd_queue[$];
    row_result_t expected_rows[$];
    int          cmds_in_flight = 0;
    int          mismatch_count = 0;
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    logic        cmd_taken = 1'b0;
    mvm_cmd_t    next_cmd;

    // predictor state, updated on accepted transactions
    logic [31:0] mat_model[16][16];
    logic [31:0] vec_model[16];
    logic [4:0]  rows_reg = 5'd16;
    logic [4:0]  cols_reg = 5'd16;

    // stimulus-side bookkeeping so that no unwritten entry is ever read
    bit          mat_written[16][16];
    bit          vec_written[16];
    int          gen_rows = 16;
    int          gen_cols = 16;

    matrix_vector_multiply_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int count_in_use(logic [4:0] v);
        if (v == 5'd0)
            return 1;
        if (v > 5'd16)
            return 16;
        return int'(v);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            4: return $urandom_range(200) - 32'd100;
            default: return $urandom();
        endcase
    endfunction

    task automatic apply_command(mvm_cmd_t c);
        int          nr;
        int          nc;
        logic [31:0] acc;
        row_result_t r;
        nr = count_in_use(rows_reg);
        nc = count_in_use(cols_reg);
        case (c.cmd)
            CMD_WR_MATRIX:
                if (c.row < nr && c.col < nc)
                    mat_model[c.row][c.col] = c.value;
            CMD_WR_VECTOR:
                if (c.col < nc)
                    vec_model[c.col] = c.value;
            CMD_COMPUTE:
                for (int i = 0; i < nr; i++)
                begin
                    acc = '0;
                    for (int j = 0; j < nc; j++)
                        acc = acc + mat_model[i][j] * vec_model[j];
                    r.row = i[3:0];
                    r.product = acc;
                    r.last = (i + 1 == nr);
                    expected_rows.push_back(r);
                end
            default: ;
        endcase
    endtask

    // stimulus driver
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || cmd_taken)
        begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_gap_pct)
            begin
                next_cmd = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {next_cmd.value, next_cmd.col, next_cmd.row};
                s_tuser <= next_cmd.cmd;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor and checker
    always @(posedge clk)
    begin
        mvm_cmd_t    seen;
        row_result_t want;
        cmd_taken = s_tvalid && s_tready;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_NUM_ROWS)
                rows_reg = cfg_data;
            else if (cfg_index == REG_NUM_COLS)
                cols_reg = cfg_data;
        end
        if (rst_n && cmd_taken)
        begin
            seen.cmd = cmd_t'(s_tuser);
            seen.row = s_tdata[3:0];
            seen.col = s_tdata[7:4];
            seen.value = s_tdata[39:8];
            apply_command(seen);
            cmds_in_flight--;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_rows.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got row %0d product %08h last %0b",
                         $time, m_tdata[3:0], m_tdata[35:4], m_tlast);
            end
            else
            begin
                want = expected_rows.pop_front();
                if (m_tdata[3:0] !== want.row || m_tdata[35:4] !== want.product
                    || m_tlast !== want.last || m_tdata[39:36] !== 4'h0)
                begin
                    mismatch_count++;
                    $display({"%0t: mismatch, expected row %0d product %08h last %0b,",
                              " got row %0d product %08h last %0b pad %h"},
                             $time, want.row, want.product, want.last,
                             m_tdata[3:0], m_tdata[35:4], m_tlast, m_tdata[39:36]);
                end
            end
        end
    end

    task automatic queue_cmd(cmd_t cmd, int row, int col, logic [31:0] value);
        mvm_cmd_t c;
        c.cmd = cmd;
        c.row = row[3:0];
        c.col = col[3:0];
        c.value = value;
        if (cmd == CMD_WR_MATRIX && row < gen_rows && col < gen_cols)
            mat_written[row][col] = 1'b1;
        if (cmd == CMD_WR_VECTOR && col < gen_cols)
            vec_written[col] = 1'b1;
        cmds_in_flight++;
        cmd_queue.push_back(c);
    endtask

    // loads whatever the compute would read but was never written, then computes
    task automatic queue_compute();
        for (int i = 0; i < gen_rows; i++)
            for (int j = 0; j < gen_cols; j++)
                if (!mat_written[i][j])
                    queue_cmd(CMD_WR_MATRIX, i, j, pick_value());
        for (int j = 0; j < gen_cols; j++)
            if (!vec_written[j])
                queue_cmd(CMD_WR_VECTOR, 0, j, pick_value());
        queue_cmd(CMD_COMPUTE, $urandom_range(15), $urandom_range(15), $urandom());
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (cmds_in_flight != 0 || expected_rows.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CNT_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_sizes(logic [4:0] rows_val, logic [4:0] cols_val);
        write_reg(REG_NUM_ROWS, rows_val);
        write_reg(REG_NUM_COLS, cols_val);
        gen_rows = count_in_use(rows_val);
        gen_cols = count_in_use(cols_val);
    endtask

    // sizes are 2 rows by 3 columns here
    task automatic run_directed();
        queue_cmd(CMD_WR_MATRIX, 0, 0, 32'h8000_0000);
        queue_cmd(CMD_WR_MATRIX, 0, 1, 32'h7fff_ffff);
        queue_cmd(CMD_WR_MATRIX, 0, 2, 32'hffff_ffff);
        queue_cmd(CMD_WR_MATRIX, 1, 0, 32'h0000_0001);
        queue_cmd(CMD_WR_MATRIX, 1, 1, 32'h0000_0000);
        queue_cmd(CMD_WR_MATRIX, 1, 2, 32'h8000_0000);
        queue_cmd(CMD_WR_VECTOR, 0, 0, 32'h7fff_ffff);
        queue_cmd(CMD_WR_VECTOR, 0, 1, 32'hffff_ffff);
        queue_cmd(CMD_WR_VECTOR, 0, 2, 32'h8000_0000);
        // writes outside the sizes in use and the unused command
        queue_cmd(CMD_WR_MATRIX, 2, 0, 32'h1234_5678);
        queue_cmd(CMD_WR_MATRIX, 0, 3, 32'h1234_5678);
        queue_cmd(CMD_WR_MATRIX, 15, 15, 32'hffff_ffff);
        queue_cmd(CMD_WR_VECTOR, 15, 15, 32'hffff_ffff);
        queue_cmd(CMD_NONE, 15, 15, 32'hffff_ffff);
        queue_cmd(CMD_COMPUTE, 0, 0, 32'h0000_0000);
        queue_cmd(CMD_WR_VECTOR, 0, 1, 32'h0000_0001);
        queue_cmd(CMD_WR_MATRIX, 1, 1, 32'h7fff_ffff);
        queue_cmd(CMD_COMPUTE, 15, 15, 32'hffff_ffff);
    endtask

    task automatic run_random(int target);
        int start_count;
        int n;
        start_count = cmds_in_flight;
        n = 0;
        while (n < target)
        begin
            if ($urandom_range(99) < 65)
            begin
                repeat ($urandom_range(6))
                begin
                    if ($urandom_range(1))
                        queue_cmd(CMD_WR_MATRIX, $urandom_range(gen_rows - 1),
                                  $urandom_range(gen_cols - 1), pick_value());
                    else
                        queue_cmd(CMD_WR_VECTOR, $urandom_range(15),
                                  $urandom_range(gen_cols - 1), pick_value());
                    n++;
                end
                queue_compute();
                n++;
                if ($urandom_range(9) == 0)
                    wait_idle();
            end
            else
            begin
                case ($urandom_range(3))
                    0: queue_cmd(CMD_WR_MATRIX, $urandom_range(15), $urandom_range(15),
                                 pick_value());
                    1: queue_cmd(CMD_WR_VECTOR, $urandom_range(15), $urandom_range(15),
                                 pick_value());
                    2: queue_compute();
                    default: queue_cmd(CMD_NONE, $urandom_range(15), $urandom_range(15),
                                       $urandom());
                endcase
                n++;
            end
        end
    endtask

    initial
    begin
        logic [4:0] phase_rows[9];
        logic [4:0] phase_cols[9];
        phase_rows = '{5'd2, 5'd0, 5'd1, 5'd16, 5'd31, 5'd1, 5'd3, 5'd0, 5'd0};
        phase_cols = '{5'd3, 5'd0, 5'd16, 5'd1, 5'd1, 5'd31, 5'd5, 5'd0, 5'd0};
        for (int p = 7; p < 9; p++)
        begin
            phase_rows[p] = 5'($urandom_range(1, 4));
            phase_cols[p] = 5'($urandom_range(1, 4));
        end
        for (int i = 0; i < 16; i++)
        begin
            vec_model[i] = '0;
            vec_written[i] = 1'b0;
            for (int j = 0; j < 16; j++)
            begin
                mat_model[i][j] = '0;
                mat_written[i][j] = 1'b0;
            end
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 9; p++)
        begin
            if (p < 3)
            begin
                send_gap_pct = 24;
                recv_stall_pct = 73;
            end
            else if (p < 6)
            begin
                send_gap_pct = 73;
                recv_stall_pct = 24;
            end
            else
            begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            wait_idle();
            set_sizes(phase_rows[p], phase_cols[p]);
            if (p == 0)
                run_directed();
            else
                run_random(3);
        end
        wait_idle();
        repeat (30) @(negedge clk);
        if (mismatch_count == 0 && expected_rows.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
